>>> rtl/hfx_pkg.sv
// shared types, constants and lookup functions of the http request field extractor
package hfx_pkg;

	localparam int PAYLOAD_LIMIT_DEF = 4095;
	localparam int FIELD_MAX_DEF     = 255;
	localparam int CNT_W             = 13;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QUEUE_AW          = 2;
	localparam int VERB_COUNT        = 7;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;
	localparam logic [CNT_W-1:0] MIN_PACKET = 13'd10;

	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_VT  = 8'd11;
	localparam logic [7:0] CH_FF  = 8'd12;

	// configuration register indexes
	localparam logic [1:0] REG_URI_LIMIT   = 2'd0;
	localparam logic [1:0] REG_HOST_LIMIT  = 2'd1;
	localparam logic [1:0] REG_AGENT_LIMIT = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_URI     = 3'd1;
	localparam logic [2:0] KIND_HOST    = 3'd2;
	localparam logic [2:0] KIND_AGENT   = 3'd3;
	localparam logic [2:0] KIND_VERDICT = 3'd4;

	typedef enum logic [3:0] {
		PH_METHOD    = 4'd0,
		PH_URI_SKIP  = 4'd1,
		PH_URI       = 4'd2,
		PH_URI_REST  = 4'd3,
		PH_HDR_NAME  = 4'd4,
		PH_HDR_SKIP  = 4'd5,
		PH_HDR_VALUE = 4'd6,
		PH_LINE_SKIP = 4'd7,
		PH_DONE      = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [2:0] item_kind;
		logic       field_start;
		logic       has_char;
		logic [7:0] char_value;
		logic       verdict;
		logic       last;
	} out_item_t;

	// what one byte leaves for the back end: an optional field item and an optional verdict
	typedef struct packed {
		logic      fld_v;
		out_item_t fld;
		logic      vrd_v;
		logic      vrd;
	} entry_t;

	function automatic logic [3:0] verb_length(input logic [2:0] i);
		logic [3:0] r;
		case (i)
			3'd0: r = 4'd4;
			3'd1: r = 4'd5;
			3'd2: r = 4'd4;
			3'd3: r = 4'd7;
			3'd4: r = 4'd5;
			3'd5: r = 4'd8;
			3'd6: r = 4'd6;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] verb_char(input logic [2:0] i, input logic [2:0] p);
		logic [63:0] txt;
		case (i)
			3'd0: txt = {"GET ", 32'd0};
			3'd1: txt = {"POST ", 24'd0};
			3'd2: txt = {"PUT ", 32'd0};
			3'd3: txt = {"DELETE ", 8'd0};
			3'd4: txt = {"HEAD ", 24'd0};
			3'd5: txt = "OPTIONS ";
			3'd6: txt = {"PATCH ", 16'd0};
			default: txt = 64'd0;
		endcase
		return txt[8*(7-p) +: 8];
	endfunction

	function automatic logic [7:0] host_char(input logic [3:0] p);
		logic [39:0] txt;
		txt = "host:";
		return (p < 4'd5) ? txt[8*(4-p[2:0]) +: 8] : 8'd0;
	endfunction

	function automatic logic [7:0] agent_char(input logic [3:0] p);
		logic [87:0] txt;
		txt = "user-agent:";
		return (p < 4'd11) ? txt[8*(10-p) +: 8] : 8'd0;
	endfunction

endpackage

>>> rtl/hfx_front.sv
// front end: configuration registers and byte-wise request parser
module hfx_front #(
	parameter int PAYLOAD_LIMIT = hfx_pkg::PAYLOAD_LIMIT_DEF,
	parameter int FIELD_MAX     = hfx_pkg::FIELD_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  hfx_pkg::in_item_t item,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [7:0]        cfg_val,
	output logic              push,
	output hfx_pkg::entry_t   entry
);

	logic [7:0] uri_lim_q, host_lim_q, agent_lim_q;
	logic [hfx_pkg::CNT_W-1:0] count_q, n_count;
	logic [6:0] vcand_q, n_vcand;
	hfx_pkg::phase_t phase_q, n_phase;
	logic [3:0] npos_q, n_npos;
	logic [1:0] hcand_q, n_hcand;
	logic [7:0] flen_q, n_flen;
	logic prev_cr_q, n_prev_cr, empty_q, n_empty, uri_q, n_uri, stop_q, n_stop;

	logic [7:0] b, lc, eff_uri, eff_host, eff_agent, hlim, lim, base_len;
	logic [hfx_pkg::CNT_W-1:0] pos;
	logic is_end, is_ignore, done, fc, fc_start, fc_has;
	logic [2:0] fc_kind;
	logic [6:0] vc;
	logic [1:0] hc;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uri_lim_q   <= 8'd255;
			host_lim_q  <= 8'd255;
			agent_lim_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_idx)
				hfx_pkg::REG_URI_LIMIT:   uri_lim_q   <= cfg_val;
				hfx_pkg::REG_HOST_LIMIT:  host_lim_q  <= cfg_val;
				hfx_pkg::REG_AGENT_LIMIT: agent_lim_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// limits capped at the field maximum
	assign eff_uri   = (uri_lim_q > 8'(FIELD_MAX)) ? 8'(FIELD_MAX) : uri_lim_q;
	assign eff_host  = (host_lim_q > 8'(FIELD_MAX)) ? 8'(FIELD_MAX) : host_lim_q;
	assign eff_agent = (agent_lim_q > 8'(FIELD_MAX)) ? 8'(FIELD_MAX) : agent_lim_q;

	// parser next state and emitted items
	always_comb begin
		n_count   = count_q;
		n_vcand   = vcand_q;
		n_phase   = phase_q;
		n_npos    = npos_q;
		n_hcand   = hcand_q;
		n_flen    = flen_q;
		n_prev_cr = prev_cr_q;
		n_empty   = empty_q;
		n_uri     = uri_q;
		entry     = '0;
		b         = item.data_byte;
		pos       = count_q;
		lc        = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		is_end    = 1'b0;
		is_ignore = 1'b0;
		done      = 1'b0;
		fc        = 1'b0;
		fc_start  = 1'b0;
		fc_kind   = hfx_pkg::KIND_URI;
		vc        = vcand_q;
		hc        = hcand_q;
		hlim      = (hcand_q == 2'd1) ? eff_host : eff_agent;
		lim       = eff_uri;
		base_len  = flen_q;
		fc_has    = 1'b0;

		if (count_q < hfx_pkg::COUNT_MAX)
			n_count = count_q + 1'b1;
		n_stop = stop_q || (pos >= hfx_pkg::CNT_W'(PAYLOAD_LIMIT)) || (b == 8'd0);

		if (!n_stop) begin
			if (phase_q == hfx_pkg::PH_METHOD) begin
				// verb match across all candidates
				for (int i = 0; i < hfx_pkg::VERB_COUNT; i++) begin
					if (vc[i]) begin
						if (pos < {9'd0, hfx_pkg::verb_length(3'(i))} &&
						    b == hfx_pkg::verb_char(3'(i), pos[2:0])) begin
							if ((pos + 1'b1) == {9'd0, hfx_pkg::verb_length(3'(i))})
								done = 1'b1;
						end else begin
							vc[i] = 1'b0;
						end
					end
				end
				n_vcand = vc;
				if (vc == 7'd0) begin
					n_phase = hfx_pkg::PH_DONE;
				end else if (done) begin
					n_phase = hfx_pkg::PH_URI_SKIP;
				end else begin
					entry.fld_v = 1'b1;
					entry.fld.item_kind = hfx_pkg::KIND_METHOD;
					entry.fld.field_start = (pos == '0);
					entry.fld.has_char = 1'b1;
					entry.fld.char_value = b;
				end
			end else if (phase_q != hfx_pkg::PH_DONE) begin
				// line end classification
				if (b == hfx_pkg::CH_CR) begin
					is_end = 1'b1;
					n_prev_cr = 1'b1;
				end else if (b == hfx_pkg::CH_LF) begin
					is_ignore = prev_cr_q;
					is_end = !prev_cr_q;
					n_prev_cr = 1'b0;
				end else begin
					n_prev_cr = 1'b0;
				end

				if (is_end) begin
					if (phase_q == hfx_pkg::PH_URI_SKIP ||
					    (phase_q == hfx_pkg::PH_HDR_NAME && empty_q)) begin
						n_phase = hfx_pkg::PH_DONE;
					end else begin
						n_phase = hfx_pkg::PH_HDR_NAME;
						n_npos  = 4'd0;
						n_hcand = 2'd3;
						n_empty = 1'b1;
					end
				end else if (!is_ignore) begin
					n_empty = 1'b0;
					case (phase_q)
						hfx_pkg::PH_URI_SKIP: begin
							if (!(b == hfx_pkg::CH_SP || b == hfx_pkg::CH_TAB ||
							      b == hfx_pkg::CH_VT || b == hfx_pkg::CH_FF)) begin
								n_uri = 1'b1;
								n_phase = hfx_pkg::PH_URI;
								base_len = 8'd0;
								fc = 1'b1;
								fc_start = 1'b1;
							end
						end
						hfx_pkg::PH_URI: begin
							if (b == hfx_pkg::CH_SP || b == hfx_pkg::CH_TAB ||
							    b == hfx_pkg::CH_VT || b == hfx_pkg::CH_FF)
								n_phase = hfx_pkg::PH_URI_REST;
							else
								fc = 1'b1;
						end
						hfx_pkg::PH_HDR_NAME: begin
							if (hc[0] && !(npos_q < 4'd5 && lc == hfx_pkg::host_char(npos_q)))
								hc[0] = 1'b0;
							if (hc[1] && !(npos_q < 4'd11 && lc == hfx_pkg::agent_char(npos_q)))
								hc[1] = 1'b0;
							if (npos_q < 4'd15)
								n_npos = npos_q + 1'b1;
							n_hcand = hc;
							if (hc == 2'd0) begin
								n_phase = hfx_pkg::PH_LINE_SKIP;
							end else if ((hc[0] && npos_q == 4'd4) ||
							             (hc[1] && npos_q == 4'd10)) begin
								n_hcand = hc[0] ? 2'd1 : 2'd2;
								n_phase = hfx_pkg::PH_HDR_SKIP;
								n_flen = 8'd0;
								entry.fld_v = 1'b1;
								entry.fld.item_kind = hc[0] ? hfx_pkg::KIND_HOST
								                            : hfx_pkg::KIND_AGENT;
								entry.fld.field_start = 1'b1;
							end
						end
						hfx_pkg::PH_HDR_SKIP: begin
							if (!(b == hfx_pkg::CH_SP || b == hfx_pkg::CH_TAB)) begin
								n_phase = hfx_pkg::PH_HDR_VALUE;
								fc = 1'b1;
								fc_kind = (hcand_q == 2'd1) ? hfx_pkg::KIND_HOST
								                            : hfx_pkg::KIND_AGENT;
								lim = hlim;
							end
						end
						hfx_pkg::PH_HDR_VALUE: begin
							fc = 1'b1;
							fc_kind = (hcand_q == 2'd1) ? hfx_pkg::KIND_HOST
							                            : hfx_pkg::KIND_AGENT;
							lim = hlim;
						end
						default: ;
					endcase

					// field character within limit
					if (fc) begin
						fc_has = base_len < lim;
						n_flen = fc_has ? base_len + 1'b1 : base_len;
						if (fc_has || fc_start) begin
							entry.fld_v = 1'b1;
							entry.fld.item_kind = fc_kind;
							entry.fld.field_start = fc_start;
							entry.fld.has_char = fc_has;
							entry.fld.char_value = fc_has ? b : 8'd0;
						end
					end
				end
			end
		end

		// verdict and packet state return at end of packet
		if (item.end_of_packet) begin
			entry.vrd_v = 1'b1;
			entry.vrd = (n_count >= hfx_pkg::MIN_PACKET) && n_uri;
			n_count   = '0;
			n_vcand   = 7'h7f;
			n_phase   = hfx_pkg::PH_METHOD;
			n_npos    = 4'd0;
			n_hcand   = 2'd3;
			n_flen    = 8'd0;
			n_prev_cr = 1'b0;
			n_empty   = 1'b1;
			n_uri     = 1'b0;
			n_stop    = 1'b0;
		end
	end

	assign push = accept && (entry.fld_v || entry.vrd_v);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			vcand_q   <= 7'h7f;
			phase_q   <= hfx_pkg::PH_METHOD;
			npos_q    <= 4'd0;
			hcand_q   <= 2'd3;
			flen_q    <= 8'd0;
			prev_cr_q <= 1'b0;
			empty_q   <= 1'b1;
			uri_q     <= 1'b0;
			stop_q    <= 1'b0;
		end else if (accept) begin
			count_q   <= n_count;
			vcand_q   <= n_vcand;
			phase_q   <= n_phase;
			npos_q    <= n_npos;
			hcand_q   <= n_hcand;
			flen_q    <= n_flen;
			prev_cr_q <= n_prev_cr;
			empty_q   <= n_empty;
			uri_q     <= n_uri;
			stop_q    <= n_stop;
		end
	end

endmodule

>>> rtl/hfx_queue.sv
// small queue of parsed entries between front and back end
module hfx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hfx_pkg::entry_t wdata,
	input  logic            pop,
	output hfx_pkg::entry_t rdata,
	output logic            empty,
	output logic            full
);

	hfx_pkg::entry_t mem [hfx_pkg::QUEUE_DEPTH];
	logic [hfx_pkg::QUEUE_AW-1:0] wr_q, rd_q;
	logic [hfx_pkg::QUEUE_AW:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (hfx_pkg::QUEUE_AW+1)'(hfx_pkg::QUEUE_DEPTH));
	assign rdata = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/hfx_back.sv
// back end: splits queued entries into result items behind an output register
module hfx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hfx_pkg::entry_t     head,
	input  logic                head_v,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output hfx_pkg::out_item_t  out_data
);

	logic valid_q, sent_q, load, send_fld;
	hfx_pkg::out_item_t data_q, nxt;

	assign load     = head_v && (!valid_q || !out_stall);
	assign send_fld = head.fld_v && !sent_q;
	assign pop      = load && !(send_fld && head.vrd_v);

	// pick field item first, then verdict
	always_comb begin
		nxt = head.fld;
		if (!send_fld) begin
			nxt = '0;
			nxt.item_kind = hfx_pkg::KIND_VERDICT;
			nxt.verdict = head.vrd;
			nxt.last = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q  <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load)
				sent_q <= send_fld && head.vrd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> rtl/http_request_field_extractor_core.sv
// top level of the http request field extractor
// a byte's items are written into the queue at its acceptance edge and then loaded into the output register
// throughput: one byte per cycle while the queue is not full; a byte ending a packet with a field item yields
// a field item and a verdict, absorbed by the four-entry queue between parser and output stage
// reset: asynchronous, clears parser state, queue and output valid; limits return to 255
module http_request_field_extractor_core #(
	parameter int PAYLOAD_LIMIT = hfx_pkg::PAYLOAD_LIMIT_DEF,
	parameter int FIELD_MAX     = hfx_pkg::FIELD_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  hfx_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output hfx_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic accept, push, pop, q_empty, q_full;
	hfx_pkg::entry_t entry, head;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign cfg_ready = 1'b1;

	hfx_front #(
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT),
		.FIELD_MAX(FIELD_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(in_data),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_idx(cfg_index),
		.cfg_val(cfg_data),
		.push(push),
		.entry(entry)
	);

	hfx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(entry),
		.pop(pop),
		.rdata(head),
		.empty(q_empty),
		.full(q_full)
	);

	hfx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_v(!q_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

>>> dv/hfx_checker.sv
// checker of the http request field extractor: request and result monitor with field predictor
`timescale 1ns / 1ps
module hfx_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  hfx_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  hfx_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count,
	output int                 good_packets
);

	localparam int PAYLOAD_LIMIT = hfx_pkg::PAYLOAD_LIMIT_DEF;

	// predictor state
	logic [7:0]                lim_uri, lim_host, lim_agent;
	logic [hfx_pkg::CNT_W-1:0] n_bytes;
	logic [6:0]                verbs_left;
	hfx_pkg::phase_t           phase;
	logic [3:0]                name_pos;
	logic [1:0]                hdr_left;
	logic [7:0]                fld_len;
	logic                      saw_cr, empty_line, got_uri, halted;

	hfx_pkg::out_item_t expected_q[$];

	function automatic logic [7:0] lim_cap(input logic [7:0] r);
		return (r > hfx_pkg::FIELD_MAX_DEF) ? 8'(hfx_pkg::FIELD_MAX_DEF) : r;
	endfunction

	function automatic hfx_pkg::out_item_t mk(input logic [2:0] k, input logic st,
			input logic hc, input logic [7:0] c, input logic vd, input logic ls);
		hfx_pkg::out_item_t o;
		o.item_kind = k; o.field_start = st; o.has_char = hc;
		o.char_value = hc ? c : 8'd0; o.verdict = vd; o.last = ls;
		return o;
	endfunction

	task automatic clear_packet();
		n_bytes = '0; verbs_left = 7'h7f; phase = hfx_pkg::PH_METHOD; name_pos = 0;
		hdr_left = 2'b11; fld_len = 0; saw_cr = 0; empty_line = 1;
		got_uri = 0; halted = 0;
	endtask

	task automatic push_char(input logic [2:0] k, input logic st, input logic [7:0] b,
			input logic [7:0] lim);
		logic hc;
		hc = fld_len < lim;
		if (hc) fld_len++;
		if (hc || st) expected_q.push_back(mk(k, st, hc, b, 0, 0));
	endtask

	// verb matching on the request line
	task automatic match_verb(input logic [7:0] b, input int pos);
		logic [6:0] c;
		logic done;
		c = verbs_left; done = 0;
		for (int i = 0; i < hfx_pkg::VERB_COUNT; i++) begin
			if (c[i]) begin
				if (pos < hfx_pkg::verb_length(3'(i)) &&
				    b == hfx_pkg::verb_char(3'(i), 3'(pos))) begin
					if (pos + 1 == hfx_pkg::verb_length(3'(i))) done = 1;
				end else c[i] = 0;
			end
		end
		verbs_left = c;
		if (c == 0) phase = hfx_pkg::PH_DONE;
		else if (done) phase = hfx_pkg::PH_URI_SKIP;
		else expected_q.push_back(mk(hfx_pkg::KIND_METHOD, pos == 0, 1, b, 0, 0));
	endtask

	// header name match, case folded
	task automatic match_name(input logic [7:0] b);
		logic [7:0] lc;
		logic [1:0] c;
		logic [3:0] p;
		string hs, as;
		hs = "host:"; as = "user-agent:";
		p = name_pos; c = hdr_left;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		if (c[0] && !(p < 5 && lc == hs[p])) c[0] = 0;
		if (c[1] && !(p < 11 && lc == as[p])) c[1] = 0;
		if (name_pos < 15) name_pos++;
		hdr_left = c;
		if (c == 0) phase = hfx_pkg::PH_LINE_SKIP;
		else if ((c[0] && p == 4) || (c[1] && p == 10)) begin
			hdr_left = c[0] ? 2'b01 : 2'b10;
			phase = hfx_pkg::PH_HDR_SKIP;
			fld_len = 0;
			expected_q.push_back(mk(c[0] ? hfx_pkg::KIND_HOST : hfx_pkg::KIND_AGENT,
				1, 0, 0, 0, 0));
		end
	endtask

	task automatic parse(input logic [7:0] b, input int pos);
		logic is_end, ign, uri_sp;
		logic [2:0] hk;
		logic [7:0] hl;
		if (phase == hfx_pkg::PH_METHOD) begin
			match_verb(b, pos);
			return;
		end
		if (phase == hfx_pkg::PH_DONE) return;
		ign = 0; is_end = 0;
		if (b == hfx_pkg::CH_CR) begin is_end = 1; saw_cr = 1; end
		else if (b == hfx_pkg::CH_LF) begin
			if (saw_cr) ign = 1; else is_end = 1;
			saw_cr = 0;
		end else saw_cr = 0;
		if (ign) return;
		// line end
		if (is_end) begin
			if (phase == hfx_pkg::PH_URI_SKIP) phase = hfx_pkg::PH_DONE;
			else if (phase == hfx_pkg::PH_HDR_NAME && empty_line) phase = hfx_pkg::PH_DONE;
			else begin
				phase = hfx_pkg::PH_HDR_NAME; name_pos = 0; hdr_left = 2'b11;
				empty_line = 1;
			end
			return;
		end
		empty_line = 0;
		hk = (hdr_left == 2'b01) ? hfx_pkg::KIND_HOST : hfx_pkg::KIND_AGENT;
		hl = lim_cap(hk == hfx_pkg::KIND_HOST ? lim_host : lim_agent);
		uri_sp = b == hfx_pkg::CH_SP || b == hfx_pkg::CH_TAB ||
		         b == hfx_pkg::CH_VT || b == hfx_pkg::CH_FF;
		case (phase)
			hfx_pkg::PH_URI_SKIP: if (!uri_sp) begin
				got_uri = 1; phase = hfx_pkg::PH_URI; fld_len = 0;
				push_char(hfx_pkg::KIND_URI, 1, b, lim_cap(lim_uri));
			end
			hfx_pkg::PH_URI: begin
				if (uri_sp) phase = hfx_pkg::PH_URI_REST;
				else push_char(hfx_pkg::KIND_URI, 0, b, lim_cap(lim_uri));
			end
			hfx_pkg::PH_HDR_NAME: match_name(b);
			hfx_pkg::PH_HDR_SKIP: if (b != hfx_pkg::CH_SP && b != hfx_pkg::CH_TAB) begin
				phase = hfx_pkg::PH_HDR_VALUE;
				push_char(hk, 0, b, hl);
			end
			hfx_pkg::PH_HDR_VALUE: push_char(hk, 0, b, hl);
			default: ;
		endcase
	endtask

	task automatic predict(input hfx_pkg::in_item_t it);
		int pos;
		logic ok;
		pos = n_bytes;
		if (n_bytes < hfx_pkg::COUNT_MAX) n_bytes++;
		if (!halted && (pos >= PAYLOAD_LIMIT || it.data_byte == 0)) halted = 1;
		if (!halted) parse(it.data_byte, pos);
		if (it.end_of_packet) begin
			ok = n_bytes >= hfx_pkg::MIN_PACKET && got_uri;
			if (ok) good_packets++;
			expected_q.push_back(mk(hfx_pkg::KIND_VERDICT, 0, 0, 0, ok, 1));
			clear_packet();
		end
	endtask

	// request, result and register write monitor
	always @(posedge clk or negedge arst_n) begin
		hfx_pkg::out_item_t exp_item;
		if (!arst_n) begin
			lim_uri = 8'd255; lim_host = 8'd255; lim_agent = 8'd255;
			clear_packet();
			expected_q.delete();
			fail_count <= 0; pending <= 0; result_count <= 0; good_packets = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_item = expected_q.pop_front();
					if (out_data !== exp_item) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_item,
							out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			// a request taken at a write edge still sees the old limits
			if (in_valid && !in_stall) predict(in_data);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hfx_pkg::REG_URI_LIMIT:   lim_uri = cfg_data;
					hfx_pkg::REG_HOST_LIMIT:  lim_host = cfg_data;
					hfx_pkg::REG_AGENT_LIMIT: lim_agent = cfg_data;
					default: ;
				endcase
			end
			pending <= expected_q.size();
		end
	end
endmodule

>>> dv/tb.sv
// testbench top of the http request field extractor: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	hfx_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1;
	hfx_pkg::out_item_t out_data;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [7:0]         cfg_data = '0;
	int                 fail_count, pending, result_count, good_packets;
	int                 bytes_sent = 0;
	int                 idle_cycles = 0;
	bit                 hold_off = 0;
	bit                 wd_fired = 0;

	localparam int WATCHDOG = 20000;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	http_request_field_extractor_core u_top (.*);

	hfx_checker u_chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver idling, with one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !wd_fired) begin
			wd_fired = 1;
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eop);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_byte: b, end_of_packet: eop};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit eop);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], eop && i == s.len() - 1);
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || u_chk.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic string rand_word(input int n, input bit sp_ok);
		string s;
		s = "";
		for (int i = 0; i < n; i++) begin
			byte c;
			c = 8'($urandom_range(33, 126));
			if (sp_ok && $urandom_range(0, 9) == 0) c = " ";
			s = {s, string'(c)};
		end
		return s;
	endfunction

	function automatic string case_mix(input string s);
		for (int i = 0; i < s.len(); i++)
			if ($urandom_range(0, 1) && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
		return s;
	endfunction

	// one well-formed request with random content, sometimes broken
	task automatic send_request();
		string verbs[7] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS", "PATCH"};
		string eol, s;
		int nh;
		if ($urandom_range(0, 3) == 0) eol = "\n";
		else eol = "\r\n";
		s = {verbs[$urandom_range(0, 6)], " "};
		if ($urandom_range(0, 1)) s = {s, "  \t"};
		s = {s, "/", rand_word($urandom_range(0, 12), 0), " HTTP/1.1", eol};
		nh = $urandom_range(0, 4);
		for (int h = 0; h < nh; h++) begin
			case ($urandom_range(0, 3))
				0: s = {s, case_mix("host:"), " ", rand_word($urandom_range(1, 14), 1), eol};
				1: s = {s, case_mix("user-agent:"), "\t ", rand_word($urandom_range(1, 20), 1),
					eol};
				2: s = {s, "Accept: ", rand_word($urandom_range(1, 8), 0), eol};
				default: s = {s, "Hos", rand_word(3, 0), eol};
			endcase
		end
		s = {s, eol, rand_word($urandom_range(0, 6), 1)};
		// broken forms
		case ($urandom_range(0, 9))
			0: s[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
			1: s[$urandom_range(0, s.len() - 1)] = 8'h00;
			2: s = s.substr(0, $urandom_range(0, 8));
			default: ;
		endcase
		send_text(s, 1);
	endtask

	initial begin
		string big;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed requests at default limits
		send_text("GET /a HTTP/1.1\r\nHost: x\r\nUser-Agent: \tab\r\n\r\n", 1);
		send_text("OPTIONS * HTTP\nhOsT:h1\nHOST:h2\n\nHost: no", 1);
		send_text("XYZ /bad HTTP/1.1", 1);
		send_text("GET \r\nHost: y\r\n", 1);
		send_text("PUT /x", 1);
		send_byte(8'hff, 0);
		send_byte(8'h00, 1);
		send_text("DELETE /\x0bq HEAD POST PATCH", 1);
		settle();

		// tight limits, then a pressure run
		write_reg(hfx_pkg::REG_URI_LIMIT, 8'd1);
		write_reg(hfx_pkg::REG_HOST_LIMIT, 8'd1);
		write_reg(hfx_pkg::REG_AGENT_LIMIT, 8'd0);
		send_text("HEAD /long/path HTTP/1.1\r\nHost: abcd\r\nuser-agent: zz\r\n\r\n", 1);
		hold_off = 1;
		send_text("PATCH /pp HTTP/1.1\r\nHost: hhhh\r\n\r\n", 1);
		settle();

		// long uri cut at the top limit
		write_reg(hfx_pkg::REG_URI_LIMIT, 8'd255);
		write_reg(hfx_pkg::REG_HOST_LIMIT, 8'd255);
		write_reg(hfx_pkg::REG_AGENT_LIMIT, 8'd255);
		big = "POST /";
		send_text(big, 0);
		for (int i = 0; i < 300; i++) send_byte(8'($urandom_range(33, 126)), i == 299);
		settle();

		// random requests over several limit settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(hfx_pkg::REG_URI_LIMIT, ph == 3 ? 8'd255 : 8'($urandom_range(0, 16)));
			write_reg(hfx_pkg::REG_HOST_LIMIT, 8'($urandom_range(0, 255)));
			write_reg(hfx_pkg::REG_AGENT_LIMIT, 8'($urandom_range(1, 12)));
			repeat (6) send_request();
			// noise packet
			repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 0);
			send_byte(8'($urandom), 1);
			settle();
		end
		settle();

		$display("sent %0d bytes, %0d results checked, %0d requests parsed",
			bytes_sent, result_count, good_packets);
		$display("limits swept from zero to full, with long receiver hold-off");
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
